FILE: hw/rtl/bsed_pkg.sv
package bsed_pkg;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// most decoded bytes one input word can release
	localparam int unsigned MaxOut = 4;

	// decoder phase, one-hot
	typedef enum logic [3:0] {
		PH_TEXT = 4'b0001,
		PH_ESC  = 4'b0010,
		PH_HEX0 = 4'b0100,
		PH_HEX1 = 4'b1000
	} phase_t;

	// decoded bytes released by one input word
	typedef struct packed {
		logic [2:0]                cnt;
		logic                      last;
		logic [MaxOut-1:0][7:0]    bytes;
	} group_t;

	// hex digit value, bit 4 set when the character is a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b1, 4'(c - 8'h37)};
		end
		return v;
	endfunction

endpackage

FILE: hw/rtl/bsed_in_if.sv
interface bsed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: hw/rtl/bsed_out_if.sv
interface bsed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hw/rtl/bsed_front.sv
module bsed_front (
	input  logic             clk,
	input  logic             arst_n,
	bsed_in_if.sink          in_ch,
	input  logic             full,
	output logic             push,
	output bsed_pkg::group_t grp
);

	typedef struct packed {
		logic             en0;
		logic [7:0]       b0;
		logic             en1;
		logic [7:0]       b1;
		bsed_pkg::phase_t nxt;
	} plain_t;

	// one byte of ordinary text, with or without a pending backslash
	function automatic plain_t plain_step(input logic esc, input logic [7:0] b,
			input logic last);
		plain_t r;
		r = '{en0: 1'b0, b0: 8'h00, en1: 1'b0, b1: 8'h00, nxt: bsed_pkg::PH_TEXT};
		if (!esc) begin
			if (b == bsed_pkg::CH_BSLASH && !last) begin
				r.nxt = bsed_pkg::PH_ESC;
			end else begin
				r.en0 = 1'b1;
				r.b0  = b;
			end
		end else begin
			r.en0 = 1'b1;
			case (b)
				bsed_pkg::CH_R:      r.b0 = bsed_pkg::CH_CR;
				bsed_pkg::CH_N:      r.b0 = bsed_pkg::CH_LF;
				bsed_pkg::CH_T:      r.b0 = bsed_pkg::CH_TAB;
				bsed_pkg::CH_BSLASH: r.b0 = bsed_pkg::CH_BSLASH;
				bsed_pkg::CH_X: begin
					if (last) begin
						r.b0  = bsed_pkg::CH_BSLASH;
						r.en1 = 1'b1;
						r.b1  = bsed_pkg::CH_X;
					end else begin
						r.en0 = 1'b0;
						r.nxt = bsed_pkg::PH_HEX0;
					end
				end
				default: begin
					r.b0  = bsed_pkg::CH_BSLASH;
					r.en1 = 1'b1;
					r.b1  = b;
				end
			endcase
		end
		return r;
	endfunction

	bsed_pkg::phase_t phase_q, phase_d;
	logic [7:0]       held_q, held_d;
	plain_t           pa, ph, pb;
	logic [4:0]       hi, lo;
	logic [4:0][7:0]  cand;
	logic [4:0]       cen;
	logic [2:0]       n;
	logic             accept;

	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && in_ch.ready;

	// classify the word against the current phase
	always_comb begin
		pa      = plain_step(phase_q == bsed_pkg::PH_ESC, in_ch.in_byte, in_ch.in_last);
		ph      = plain_step(1'b0, held_q, 1'b0);
		pb      = plain_step(ph.nxt == bsed_pkg::PH_ESC, in_ch.in_byte, in_ch.in_last);
		hi      = bsed_pkg::hex_value(held_q);
		lo      = bsed_pkg::hex_value(in_ch.in_byte);
		cand    = '0;
		cen     = '0;
		phase_d = phase_q;
		held_d  = held_q;
		case (phase_q)
			bsed_pkg::PH_HEX0: begin
				if (in_ch.in_last) begin
					cand[0] = bsed_pkg::CH_BSLASH;
					cand[1] = bsed_pkg::CH_X;
					cand[2] = in_ch.in_byte;
					cen     = 5'b00111;
					phase_d = bsed_pkg::PH_TEXT;
				end else begin
					held_d  = in_ch.in_byte;
					phase_d = bsed_pkg::PH_HEX1;
				end
			end
			bsed_pkg::PH_HEX1: begin
				if (hi[4] && lo[4]) begin
					cand[0] = {hi[3:0], lo[3:0]};
					cen     = 5'b00001;
					phase_d = bsed_pkg::PH_TEXT;
				end else begin
					// bad digit: replay the held byte and this one as text
					cand[0] = bsed_pkg::CH_BSLASH;
					cand[1] = bsed_pkg::CH_X;
					cand[2] = ph.b0;
					cand[3] = pb.b0;
					cand[4] = pb.b1;
					cen     = {pb.en1, pb.en0, ph.en0, 2'b11};
					phase_d = pb.nxt;
				end
			end
			default: begin
				cand[0] = pa.b0;
				cand[1] = pa.b1;
				cen     = {3'b000, pa.en1, pa.en0};
				phase_d = pa.nxt;
			end
		endcase
	end

	// pack the enabled bytes into consecutive slots
	always_comb begin
		grp = '0;
		n   = 3'd0;
		for (int i = 0; i < 5; i++) begin
			if (cen[i]) begin
				grp.bytes[n[1:0]] = cand[i];
				n = n + 3'd1;
			end
		end
		grp.cnt  = n;
		grp.last = in_ch.in_last;
	end

	assign push = accept && (n != 3'd0);

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bsed_pkg::PH_TEXT;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	// held hex digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 8'h00;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

FILE: hw/rtl/bsed_fifo.sv
module bsed_fifo #(
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bsed_pkg::group_t wdata,
	output logic             full,
	input  logic             pop,
	output bsed_pkg::group_t rdata,
	output logic             empty
);

	localparam int PW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	bsed_pkg::group_t    entry_q [Depth];
	logic [PW-1:0]       wptr_q, rptr_q;
	logic [CW-1:0]       count_q;

	assign full  = (count_q == CW'(Depth));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/bsed_back.sv
module bsed_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bsed_pkg::group_t head,
	input  logic             head_valid,
	output logic             pop,
	bsed_out_if.source       out_ch
);

	logic [1:0] sub_q;
	logic       final_slot;
	logic       take;

	assign final_slot      = ({1'b0, sub_q} == head.cnt - 3'd1);
	assign out_ch.valid    = head_valid;
	assign out_ch.out_byte = head.bytes[sub_q];
	assign out_ch.out_last = head.last && final_slot;
	assign take            = out_ch.valid && out_ch.ready;
	assign pop             = take && final_slot;

	// walk through the bytes of the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 2'd0;
		end else if (take) begin
			sub_q <= final_slot ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule

FILE: hw/rtl/backslash_escape_decoder_top.sv
// channel  | dir | payload           | flow
// in_ch    | in  | in_byte, in_last  | valid/ready, one escaped byte per word
// out_ch   | out | out_byte, out_last| valid/ready, one decoded byte per word
//
// one input word per cycle while the group queue has room
// each input word releases zero to four decoded bytes; the back end sends one per cycle while out_ch ready is high
// decoded groups wait in a QDepth-entry queue, so input stalls only when it fills
// out_ch payload comes straight from the queue head and holds while ready is low
// arst_n clears the phase, the queue and the byte index at once
module backslash_escape_decoder_top #(
	parameter int QDepth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	bsed_in_if.sink    in_ch,
	bsed_out_if.source out_ch
);

	bsed_pkg::group_t push_grp, head_grp;
	logic             push, pop, full, empty;

	// classify and expand input words
	bsed_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.full   (full),
		.push   (push),
		.grp    (push_grp)
	);

	// group queue between the two sides
	bsed_fifo #(
		.Depth (QDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_grp),
		.full   (full),
		.pop    (pop),
		.rdata  (head_grp),
		.empty  (empty)
	);

	// serialize groups into output words
	bsed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_grp),
		.head_valid (!empty),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

FILE: hw/rtl/bsed_chk.sv
module bsed_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output word changed while stalled");

	// the last word of a stream always releases at least one byte
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid)
		else $error("no output after last input word");

	// nothing to send right out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind backslash_escape_decoder_top bsed_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.in_last),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.out_last)
);
